// ----- src/ewas_pkg.sv -----
// Shared types and constants for the EEPROM word access sequencer.
// No dependencies; every other file imports this package.
package ewas_pkg;

    localparam logic [15:0] CMD_WRITE     = 16'h6E20;
    localparam logic [15:0] CMD_ADDR_ONLY = 16'h2620;
    localparam logic [15:0] CMD_READ_STOP = 16'h2C20;

    localparam logic [6:0] RST_BASE_ADDR    = 7'd80;
    localparam logic [7:0] RST_WRITE_SETTLE = 8'd10;
    localparam logic [7:0] RST_READ_SETTLE  = 8'd1;
    localparam logic [7:0] RST_TIMEOUT      = 8'd50;
    localparam logic [7:0] BUSY_MAX         = 8'hFF;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        DONE_NONE  = 2'd0,
        DONE_WRITE = 2'd1,
        DONE_READ  = 2'd2
    } t_done;

    typedef enum logic [1:0] {
        CFG_BASE_ADDR    = 2'd0,
        CFG_WRITE_SETTLE = 2'd1,
        CFG_READ_SETTLE  = 2'd2,
        CFG_TIMEOUT      = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_W_START  = 4'd1,
        ST_W_ADDR   = 4'd2,
        ST_W_LOW    = 4'd3,
        ST_W_HIGH   = 4'd4,
        ST_W_SETTLE = 4'd5,
        ST_W_FINISH = 4'd6,
        ST_R_START  = 4'd7,
        ST_R_ACCESS = 4'd8,
        ST_R_FIRST  = 4'd9,
        ST_R_SECOND = 4'd10,
        ST_R_FINISH = 4'd11,
        ST_R_SETTLE = 4'd12
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  page;
        logic [6:0]  word_address;
        logic [15:0] write_data;
        logic        bus_busy;
        logic        tx_ready;
        logic        access_ready;
        logic        rx_ready;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        command_valid;
        logic [6:0]  target_address;
        logic [1:0]  byte_count;
        logic [15:0] command_word;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic [1:0]  completion;
        logic [15:0] read_word;
        logic        timeout;
    } t_out_item;

    // Input stage contents handed to the sequencer.
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_stage;

endpackage

// ----- src/ewas_seq.sv -----
// Sequencer core: configuration registers, sequence state and the per-beat step.
// Depends on ewas_pkg.
module ewas_seq
    import ewas_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  t_stage    i_stage,
    input  logic      i_commit,
    output t_out_item o_result
);

    logic [6:0]  r_base;
    logic [7:0]  r_wsettle, r_rsettle, r_tmo;

    t_state      r_state, n_state;
    logic [7:0]  r_busy, n_busy;
    logic [7:0]  r_settle, n_settle;
    logic [7:0]  r_low, n_low;
    logic [2:0]  r_page, n_page;
    logic [6:0]  r_addr, n_addr;
    logic [15:0] r_data, n_data;

    t_state      s_cur;
    logic        s_latch;
    t_in_item    s_in;
    t_out_item   s_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= RST_BASE_ADDR;
            r_wsettle <= RST_WRITE_SETTLE;
            r_rsettle <= RST_READ_SETTLE;
            r_tmo     <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_BASE_ADDR:    r_base    <= i_cfg_data[6:0];
                CFG_WRITE_SETTLE: r_wsettle <= i_cfg_data;
                CFG_READ_SETTLE:  r_rsettle <= i_cfg_data;
                CFG_TIMEOUT:      r_tmo     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= '0;
            r_settle <= '0;
            r_low    <= '0;
            r_page   <= '0;
            r_addr   <= '0;
            r_data   <= '0;
        end else if (i_commit && i_stage.valid) begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_settle <= n_settle;
            r_low    <= n_low;
            r_page   <= n_page;
            r_addr   <= n_addr;
            r_data   <= n_data;
        end
    end

    always_comb begin
        s_in    = i_stage.item;
        s_latch = (r_state == ST_IDLE) &&
                  (s_in.mode == REQ_WRITE || s_in.mode == REQ_READ);
        s_cur   = r_state;
        n_page  = r_page;
        n_addr  = r_addr;
        n_data  = r_data;
        if (s_latch) begin
            s_cur  = (s_in.mode == REQ_WRITE) ? ST_W_START : ST_R_START;
            n_page = s_in.page;
            n_addr = s_in.word_address;
            n_data = s_in.write_data;
        end
        n_state  = s_cur;
        n_busy   = (r_busy != BUSY_MAX) ? r_busy + 8'd1 : r_busy;
        n_settle = r_settle;
        n_low    = r_low;

        s_res          = '0;
        s_res.accepted = s_latch;

        case (s_cur)
            ST_W_START: begin
                if (!s_in.bus_busy) begin
                    s_res.command_valid  = 1'b1;
                    s_res.target_address = r_base + {4'b0, n_page};
                    s_res.byte_count     = 2'd3;
                    s_res.command_word   = CMD_WRITE;
                    n_state = ST_W_ADDR;
                end
            end
            ST_W_ADDR: begin
                if (s_in.tx_ready) begin
                    s_res.send_valid = 1'b1;
                    s_res.send_byte  = {n_addr, 1'b0};
                    n_state = ST_W_LOW;
                end
            end
            ST_W_LOW: begin
                if (s_in.tx_ready) begin
                    s_res.send_valid = 1'b1;
                    s_res.send_byte  = n_data[7:0];
                    n_state = ST_W_HIGH;
                end
            end
            ST_W_HIGH: begin
                if (s_in.tx_ready) begin
                    s_res.send_valid = 1'b1;
                    s_res.send_byte  = n_data[15:8];
                    n_settle = '0;
                    n_state  = ST_W_SETTLE;
                end
            end
            ST_W_SETTLE: begin
                if (r_settle >= r_wsettle) n_state = ST_W_FINISH;
                else                       n_settle = r_settle + 8'd1;
            end
            ST_W_FINISH: begin
                if (!s_in.bus_busy) begin
                    s_res.completion = DONE_WRITE;
                    n_busy  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_R_START: begin
                if (!s_in.bus_busy) begin
                    s_res.command_valid  = 1'b1;
                    s_res.target_address = r_base + {4'b0, n_page};
                    s_res.byte_count     = 2'd1;
                    s_res.command_word   = CMD_ADDR_ONLY;
                    s_res.send_valid     = 1'b1;
                    s_res.send_byte      = {n_addr, 1'b0};
                    n_state = ST_R_ACCESS;
                end
            end
            ST_R_ACCESS: begin
                if (s_in.access_ready) begin
                    s_res.command_valid  = 1'b1;
                    s_res.target_address = r_base + {4'b0, n_page};
                    s_res.byte_count     = 2'd2;
                    s_res.command_word   = CMD_READ_STOP;
                    n_settle = '0;
                    n_state  = ST_R_FIRST;
                end
            end
            ST_R_FIRST: begin
                if (s_in.rx_ready) begin
                    n_low   = s_in.rx_byte;
                    n_state = ST_R_SECOND;
                end
            end
            ST_R_SECOND: begin
                if (s_in.rx_ready) begin
                    n_data  = {s_in.rx_byte, r_low};
                    n_state = ST_R_FINISH;
                end
            end
            ST_R_FINISH: begin
                if (!s_in.bus_busy) begin
                    n_settle = '0;
                    n_state  = ST_R_SETTLE;
                end
            end
            ST_R_SETTLE: begin
                if (r_settle >= r_rsettle) begin
                    s_res.completion = DONE_READ;
                    s_res.read_word  = n_data;
                    n_busy  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_settle = r_settle + 8'd1;
                end
            end
            default: begin
                // idle with no request (and any stray code): counter held at zero
                n_state = ST_IDLE;
                n_busy  = '0;
            end
        endcase

        s_res.timeout = (n_busy >= r_tmo);
        o_result = s_res;
    end

endmodule

// ----- src/ewas_out_reg.sv -----
// Result register with valid/stall handshake toward the consumer.
// Depends on ewas_pkg.
module ewas_out_reg
    import ewas_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    input  logic      i_stall,
    output logic      o_room,
    output logic      o_valid,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;

    // room when empty or when the held beat leaves this cycle
    assign o_room  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_load) begin
            r_item <= i_result;
        end
    end

endmodule

// ----- src/eeprom_word_access_sequencer_top.sv -----
// Top level of the EEPROM word access sequencer: input register, sequencer core,
// result register. Depends on ewas_pkg, ewas_seq and ewas_out_reg.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   in      | to block  | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//   out     | from block| o_out_valid / i_out_stall  | o_out_item (t_out_item)
//   cfg     | to block  | i_cfg_we (no handshake)    | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the output is not stalled; each beat passes
// through the input register, the sequencer step and the result register, in order.
// Reset is synchronous and active low.
// A stall on the output holds the result register; the input register then
// fills and o_in_stall rises, so no beat is dropped.
module eeprom_word_access_sequencer_top
    import ewas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    t_stage    s_stage;
    logic      s_room, s_commit, s_take;
    t_out_item s_result;

    assign s_commit   = r_in_valid && s_room;
    assign o_in_stall = r_in_valid && !s_room;
    assign s_take     = i_in_valid && !o_in_stall;
    assign s_stage    = '{valid: r_in_valid, item: r_in_item};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (s_commit) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_item <= i_in_item;
        end
    end

    ewas_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stage     (s_stage),
        .i_commit    (s_commit),
        .o_result    (s_result)
    );

    ewas_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_commit),
        .i_result (s_result),
        .i_stall  (i_out_stall),
        .o_room   (s_room),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item)
    );

endmodule

// ----- src/ewas_checker.sv -----
// Port-level checks for the EEPROM word access sequencer, bound to the top level.
// Depends on ewas_pkg.
module ewas_checker
    import ewas_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_cmd_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.command_valid |->
            o_out_item.target_address == 7'd0 && o_out_item.byte_count == 2'd0 &&
            o_out_item.command_word == 16'd0)
        else $error("command fields set without command_valid");

    a_done_vs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.completion != DONE_NONE |->
            !o_out_item.accepted && o_out_item.completion != 2'd3 &&
            !o_out_item.command_valid)
        else $error("completion together with a new request or command");

    a_word_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.completion != DONE_READ |->
            o_out_item.read_word == 16'd0)
        else $error("read_word set without read completion");

    a_send_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.send_valid |-> o_out_item.send_byte == 8'd0)
        else $error("send_byte set without send_valid");

endmodule

bind eeprom_word_access_sequencer_top ewas_checker u_ewas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- sim/tb.sv -----
// Self-checking bench for eeprom_word_access_sequencer_top: drives poll beats,
// predicts every result beat in a scoreboard class and compares field by field.
// Depends on ewas_pkg and the RTL under src.
module tb
    import ewas_pkg::*;
;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_REPORTS = 50;

    class access_checker;
        // register copies
        logic [6:0]  base_addr;
        logic [7:0]  write_settle;
        logic [7:0]  read_settle;
        logic [7:0]  timeout_lim;
        // sequencer copy
        t_state      state;
        logic [7:0]  busy_cnt;
        logic [7:0]  settle_cnt;
        logic [7:0]  low_byte;
        logic [2:0]  held_page;
        logic [6:0]  held_addr;
        logic [15:0] held_data;

        t_out_item   pending_results[$];
        int          errors;
        int          writes_done;
        int          reads_done;
        int          timeouts_seen;

        function new();
            base_addr    = RST_BASE_ADDR;
            write_settle = RST_WRITE_SETTLE;
            read_settle  = RST_READ_SETTLE;
            timeout_lim  = RST_TIMEOUT;
            state        = ST_IDLE;
            busy_cnt     = '0;
            settle_cnt   = '0;
            low_byte     = '0;
            held_page    = '0;
            held_addr    = '0;
            held_data    = '0;
            errors       = 0;
            writes_done  = 0;
            reads_done   = 0;
            timeouts_seen = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [7:0] value);
            case (idx)
                CFG_BASE_ADDR:    base_addr    = value[6:0];
                CFG_WRITE_SETTLE: write_settle = value;
                CFG_READ_SETTLE:  read_settle  = value;
                CFG_TIMEOUT:      timeout_lim  = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // One accepted poll beat -> one expected result beat.
        function void predict_tick(t_in_item it);
            t_out_item r;
            r = '0;
            if (state == ST_IDLE && (it.mode == REQ_WRITE || it.mode == REQ_READ)) begin
                held_page = it.page;
                held_addr = it.word_address;
                held_data = it.write_data;
                state     = (it.mode == REQ_WRITE) ? ST_W_START : ST_R_START;
                r.accepted = 1'b1;
            end
            if (busy_cnt != BUSY_MAX)
                busy_cnt++;
            case (state)
                ST_W_START: if (!it.bus_busy) begin
                    r.command_valid  = 1'b1;
                    r.target_address = base_addr + 7'(held_page);
                    r.byte_count     = 2'd3;
                    r.command_word   = CMD_WRITE;
                    state = ST_W_ADDR;
                end
                ST_W_ADDR: if (it.tx_ready) begin
                    r.send_valid = 1'b1;
                    r.send_byte  = {held_addr, 1'b0};
                    state = ST_W_LOW;
                end
                ST_W_LOW: if (it.tx_ready) begin
                    r.send_valid = 1'b1;
                    r.send_byte  = held_data[7:0];
                    state = ST_W_HIGH;
                end
                ST_W_HIGH: if (it.tx_ready) begin
                    r.send_valid = 1'b1;
                    r.send_byte  = held_data[15:8];
                    settle_cnt = '0;
                    state = ST_W_SETTLE;
                end
                ST_W_SETTLE: begin
                    if (settle_cnt >= write_settle)
                        state = ST_W_FINISH;
                    else
                        settle_cnt++;
                end
                ST_W_FINISH: if (!it.bus_busy) begin
                    r.completion = DONE_WRITE;
                    busy_cnt = '0;
                    state = ST_IDLE;
                end
                ST_R_START: if (!it.bus_busy) begin
                    r.command_valid  = 1'b1;
                    r.target_address = base_addr + 7'(held_page);
                    r.byte_count     = 2'd1;
                    r.command_word   = CMD_ADDR_ONLY;
                    r.send_valid     = 1'b1;
                    r.send_byte      = {held_addr, 1'b0};
                    state = ST_R_ACCESS;
                end
                ST_R_ACCESS: if (it.access_ready) begin
                    r.command_valid  = 1'b1;
                    r.target_address = base_addr + 7'(held_page);
                    r.byte_count     = 2'd2;
                    r.command_word   = CMD_READ_STOP;
                    settle_cnt = '0;
                    state = ST_R_FIRST;
                end
                ST_R_FIRST: if (it.rx_ready) begin
                    low_byte = it.rx_byte;
                    state = ST_R_SECOND;
                end
                ST_R_SECOND: if (it.rx_ready) begin
                    held_data = {it.rx_byte, low_byte};
                    state = ST_R_FINISH;
                end
                ST_R_FINISH: if (!it.bus_busy) begin
                    settle_cnt = '0;
                    state = ST_R_SETTLE;
                end
                ST_R_SETTLE: begin
                    if (settle_cnt >= read_settle) begin
                        r.completion = DONE_READ;
                        r.read_word  = held_data;
                        busy_cnt = '0;
                        state = ST_IDLE;
                    end else begin
                        settle_cnt++;
                    end
                end
                default: begin
                    // idle (and any stray code) clears the busy count
                    state = ST_IDLE;
                    busy_cnt = '0;
                end
            endcase
            r.timeout = (busy_cnt >= timeout_lim);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %h, got %h", $time, name, want, got);
                else if (errors == MAX_REPORTS + 1)
                    $display("%0t: further mismatches not shown", $time);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none, got %h",
                         $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("accepted",       want.accepted,       got.accepted);
            compare_field("command_valid",  want.command_valid,  got.command_valid);
            compare_field("target_address", want.target_address, got.target_address);
            compare_field("byte_count",     want.byte_count,     got.byte_count);
            compare_field("command_word",   want.command_word,   got.command_word);
            compare_field("send_valid",     want.send_valid,     got.send_valid);
            compare_field("send_byte",      want.send_byte,      got.send_byte);
            compare_field("completion",     want.completion,     got.completion);
            compare_field("read_word",      want.read_word,      got.read_word);
            compare_field("timeout",        want.timeout,        got.timeout);
            if (want.completion == DONE_WRITE) writes_done++;
            if (want.completion == DONE_READ)  reads_done++;
            if (want.timeout)                  timeouts_seen++;
        endfunction
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = CFG_BASE_ADDR;
    logic [7:0] cfg_data  = '0;

    access_checker sb;
    bit no_idle     = 1'b0;
    int beats_sent  = 0;
    int results     = 0;
    int hold_left   = 0;
    int quiet_count = 0;
    int settings    = 0;

    eeprom_word_access_sequencer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: check accepted beats, then choose next cycle's stall.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_item);
            results++;
            // long hold-off so the block backs up into its input
            if (results == 150 || results == 900)
                hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !no_idle && ($urandom_range(99) < 38);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic t_in_item poll(t_req mode, logic [2:0] page, logic [6:0] addr,
                                      logic [15:0] data, logic bb, logic xr, logic ar,
                                      logic rr, logic [7:0] rx);
        t_in_item it;
        it.mode         = mode;
        it.page         = page;
        it.word_address = addr;
        it.write_data   = data;
        it.bus_busy     = bb;
        it.tx_ready     = xr;
        it.access_ready = ar;
        it.rx_ready     = rr;
        it.rx_byte      = rx;
        return it;
    endfunction

    // Mostly plausible controller status with random content, some raw noise.
    function automatic t_in_item random_poll(bit bus_stuck);
        logic [63:0] wide;
        logic [$bits(t_in_item)-1:0] raw;
        t_in_item it;
        int pick;
        wide = {$urandom(), $urandom()};
        raw = wide[$bits(t_in_item)-1:0];
        it = raw;
        if ($urandom_range(99) >= 10) begin
            pick = $urandom_range(99);
            if (pick < 30)      it.mode = REQ_WRITE;
            else if (pick < 60) it.mode = REQ_READ;
            else if (pick < 90) it.mode = REQ_NONE;
            else                it.mode = REQ_RSVD;
            it.bus_busy     = ($urandom_range(99) < 20);
            it.tx_ready     = ($urandom_range(99) < 75);
            it.access_ready = ($urandom_range(99) < 75);
            it.rx_ready     = ($urandom_range(99) < 75);
        end
        if (bus_stuck)
            it.bus_busy = 1'b1;
        return it;
    endfunction

    task automatic send_poll(t_in_item it);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < 38) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.predict_tick(it);
        beats_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(logic [6:0] base, logic [7:0] ws, logic [7:0] rs,
                                logic [7:0] tmo);
        t_cfg_reg   regs[4] = '{CFG_BASE_ADDR, CFG_WRITE_SETTLE, CFG_READ_SETTLE,
                                CFG_TIMEOUT};
        logic [7:0] vals[4];
        vals = '{{1'b0, base}, ws, rs, tmo};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_register(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(logic [6:0] base, logic [7:0] ws, logic [7:0] rs,
                             logic [7:0] tmo, int n, bit quiet, bit bus_stuck);
        wait_drained();
        write_config(base, ws, rs, tmo);
        no_idle = quiet;
        for (int i = 0; i < n; i++)
            send_poll(random_poll(bus_stuck && i < n - 30));
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: page/base wrap, zero settle, small timeout
        write_config(7'd127, 8'd0, 8'd0, 8'd4);
        send_poll(poll(REQ_RSVD,  7, 127, 16'hFFFF, 0, 1, 1, 1, 8'hFF));
        send_poll(poll(REQ_WRITE, 7, 127, 16'hFFFF, 1, 0, 0, 0, 8'h00));
        send_poll(poll(REQ_READ,  0,   0, 16'h0000, 0, 1, 1, 1, 8'h00)); // ignored
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 1, 0, 0, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 0, 0, 0, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 1, 0, 0, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 1, 0, 0, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 1, 1, 1, 1, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 1, 1, 1, 1, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 1, 1, 1, 8'h00));
        send_poll(poll(REQ_READ,  0,   0, 16'h0000, 0, 0, 0, 0, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 0, 1, 0, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 0, 0, 1, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 0, 0, 1, 8'hFF));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 1, 0, 0, 0, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 0, 0, 0, 8'h00));
        send_poll(poll(REQ_NONE,  0,   0, 16'h0000, 0, 0, 0, 0, 8'h00));
        send_poll(poll(REQ_WRITE, 0,   0, 16'h0000, 0, 1, 1, 1, 8'h00));
        for (int i = 0; i < 5; i++)
            send_poll(poll(REQ_NONE, 0, 0, 16'h0000, 0, 1, 1, 1, 8'h00));

        run_phase(7'd80,  8'd10,  8'd1,   8'd50,  300, 1'b0, 1'b0);
        run_phase(7'd0,   8'd0,   8'd0,   8'd1,   250, 1'b1, 1'b0);
        run_phase(7'd127, 8'd255, 8'd255, 8'd128, 350, 1'b0, 1'b0);
        run_phase(7'd121, 8'd3,   8'd2,   8'd0,   250, 1'b0, 1'b0);
        // bus held busy long enough for the busy count to saturate
        run_phase(7'($urandom_range(127)), 8'd5, 8'd5, 8'd255, 300, 1'b0, 1'b1);
        run_phase(7'($urandom_range(127)), 8'($urandom_range(12)),
                  8'($urandom_range(12)), 8'($urandom_range(1, 40)), 300, 1'b0, 1'b0);
        wait_drained();

        $display("tb: %0d poll beats, %0d results checked under %0d register settings",
                 beats_sent, results, settings);
        $display("tb: %0d word writes and %0d word reads completed, %0d timeout beats",
                 sb.writes_done, sb.reads_done, sb.timeouts_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- eeprom_word_access_sequencer_top.f -----
src/ewas_pkg.sv
src/ewas_seq.sv
src/ewas_out_reg.sv
src/eeprom_word_access_sequencer_top.sv
src/ewas_checker.sv
sim/tb.sv
